>>> hw/rtl/x86e_pkg.sv
package x86e_pkg;

    localparam int MEM_BYTES_DEF = 65536;
    localparam int NUM_REGS      = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int IN_W          = 56;
    localparam int OUT_W         = 56;

    localparam logic [2:0] REG_BX = 3'd1;
    localparam logic [2:0] REG_BP = 3'd5;
    localparam logic [2:0] REG_SI = 3'd6;

    typedef enum logic [2:0] {
        OP_MOV   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_CMP   = 3'd3,
        OP_JNZ   = 3'd4,
        OP_UNSUP = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REG  = 2'd1,
        KIND_MEM  = 2'd2,
        KIND_IMM  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PART_LO   = 2'd0,
        PART_HI   = 2'd1,
        PART_WORD = 2'd2
    } part_t;

    typedef enum logic [1:0] {
        AM_DIRECT  = 2'd0,
        AM_BX_DISP = 2'd1,
        AM_BP_DISP = 2'd2,
        AM_BP_SI   = 2'd3
    } amode_t;

    typedef struct packed {
        op_t         op;
        logic        wide;
        kind_t       dst_kind;
        logic [2:0]  dst_reg;
        part_t       dst_part;
        kind_t       src_kind;
        logic [2:0]  src_reg;
        part_t       src_part;
        amode_t      addr_mode;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [2:0]  len;
    } uop_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] result_value;
        logic        unsupported;
        logic        sign_flag;
        logic        zero_flag;
        logic [15:0] final_ip;
        logic [15:0] sequential_ip;
    } res_t;

endpackage

>>> hw/rtl/x86e_ram.sv
module x86e_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/x86e_front.sv
module x86e_front import x86e_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            clearing,
    output logic            uop_valid,
    output uop_t            uop,
    input  logic            uop_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic part_t to_part(input logic [1:0] p);
        part_t r;
        case (p)
            2'd0:    r = PART_LO;
            2'd1:    r = PART_HI;
            default: r = PART_WORD;
        endcase
        return r;
    endfunction

    function automatic uop_t decode(input logic [IN_W-1:0] d);
        uop_t u;
        u.op        = (d[2:0] inside {[3'd0:3'd4]}) ? op_t'(d[2:0]) : OP_UNSUP;
        u.wide      = d[3];
        u.dst_kind  = kind_t'(d[5:4]);
        u.dst_reg   = d[8:6];
        u.dst_part  = to_part(d[10:9]);
        u.src_kind  = kind_t'(d[12:11]);
        u.src_reg   = d[15:13];
        u.src_part  = to_part(d[17:16]);
        u.addr_mode = amode_t'(d[19:18]);
        u.disp      = d[35:20];
        u.imm       = d[51:36];
        u.len       = d[54:52];
        return u;
    endfunction

    uop_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;

    assign s_tready  = (count_reg != CNT_W'(QUEUE_DEPTH)) && !clearing;
    assign push      = s_tvalid && s_tready;
    assign uop_valid = (count_reg != '0);
    assign uop       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (uop_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !uop_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && uop_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decode(s_tdata);
        end
    end

endmodule

>>> hw/rtl/x86e_back.sv
module x86e_back import x86e_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             uop_valid,
    input  uop_t             uop,
    output logic             uop_pop,
    output logic             clearing,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    // MEM_BYTES must be a power of two (not checked here). The byte store is split
    // into even and odd banks so an unaligned word is one access to each bank.
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int BANK_DEPTH = MEM_BYTES / 2;
    localparam int BANK_W     = ADDR_W - 1;
    localparam int RF_W       = $clog2(NUM_REGS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_READ  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    function automatic logic [15:0] part_read(input logic [15:0] v, input part_t p);
        logic [15:0] r;
        case (p)
            PART_LO: r = {8'h00, v[7:0]};
            PART_HI: r = {8'h00, v[15:8]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] operand(input kind_t k, input logic [15:0] regv,
                                            input part_t p, input logic [15:0] memv,
                                            input logic [15:0] imm);
        logic [15:0] r;
        case (k)
            KIND_REG: r = part_read(regv, p);
            KIND_MEM: r = memv;
            KIND_IMM: r = imm;
            default:  r = 16'h0000;
        endcase
        return r;
    endfunction

    state_t            state_reg;
    state_t            state_next;
    logic [BANK_W-1:0] clr_idx_reg;
    uop_t              cur_reg;
    logic [15:0]       addr_reg;
    logic [15:0]       ip_reg;
    logic              zf_reg;
    logic              zf_next;
    logic              sf_reg;
    logic              sf_next;
    logic [15:0]       bx_reg;
    logic [15:0]       bp_reg;
    logic [15:0]       si_reg;
    logic              out_valid_reg;
    res_t              out_data_reg;

    logic              start;
    logic              commit;
    logic [15:0]       addr_calc;
    logic [ADDR_W-1:0] rd_idx;
    logic [BANK_W-1:0] even_raddr;
    logic [BANK_W-1:0] odd_raddr;
    logic [7:0]        even_q;
    logic [7:0]        odd_q;
    logic [15:0]       rf_dst_q;
    logic [15:0]       rf_src_q;

    logic [ADDR_W-1:0] ex_idx;
    logic [BANK_W-1:0] ex_base;
    logic              odd_addr;
    logic [15:0]       mem_word;
    logic [15:0]       mask;
    logic [15:0]       dv;
    logic [15:0]       sv;
    logic [15:0]       alu_v;
    logic [15:0]       v;
    logic              is_alu;
    logic              is_write_op;
    logic              reg_store;
    logic              mem_store;
    logic [15:0]       reg_new;
    logic [15:0]       seq_ip;
    logic [15:0]       fin_ip;
    res_t              res;

    logic              even_we;
    logic [BANK_W-1:0] even_waddr;
    logic [7:0]        even_wdata;
    logic              odd_we;
    logic [BANK_W-1:0] odd_waddr;
    logic [7:0]        odd_wdata;
    logic              rf_we;
    logic [RF_W-1:0]   rf_waddr;
    logic [15:0]       rf_wdata;

    assign clearing = (state_reg == ST_CLEAR);
    assign start    = (state_reg == ST_READ) && uop_valid;
    assign uop_pop  = start;
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        case (uop.addr_mode)
            AM_DIRECT:  addr_calc = uop.disp;
            AM_BX_DISP: addr_calc = bx_reg + uop.disp;
            AM_BP_DISP: addr_calc = bp_reg + uop.disp;
            AM_BP_SI:   addr_calc = bp_reg + si_reg;
            default:    addr_calc = uop.disp;
        endcase
    end

    assign rd_idx     = addr_calc[ADDR_W-1:0];
    assign odd_raddr  = rd_idx[ADDR_W-1:1];
    assign even_raddr = rd_idx[ADDR_W-1:1] + BANK_W'(rd_idx[0]);

    assign ex_idx   = addr_reg[ADDR_W-1:0];
    assign ex_base  = ex_idx[ADDR_W-1:1];
    assign odd_addr = ex_idx[0];
    assign mem_word = odd_addr ? {even_q, odd_q} : {odd_q, even_q};

    always_comb
    begin
        mask        = cur_reg.wide ? 16'hFFFF : 16'h00FF;
        dv          = operand(cur_reg.dst_kind, rf_dst_q, cur_reg.dst_part, mem_word,
                              cur_reg.imm) & mask;
        sv          = operand(cur_reg.src_kind, rf_src_q, cur_reg.src_part, mem_word,
                              cur_reg.imm) & mask;
        alu_v       = ((cur_reg.op == OP_ADD) ? dv + sv : dv - sv) & mask;
        is_alu      = (cur_reg.op inside {OP_ADD, OP_SUB, OP_CMP});
        is_write_op = (cur_reg.op inside {OP_MOV, OP_ADD, OP_SUB});
        v           = (cur_reg.op == OP_MOV) ? sv : alu_v;
        reg_store   = is_write_op && (cur_reg.dst_kind == KIND_REG);
        mem_store   = is_write_op && (cur_reg.dst_kind == KIND_MEM);
        zf_next     = zf_reg;
        sf_next     = sf_reg;
        if (is_alu)
        begin
            zf_next = (alu_v == 16'h0000);
            sf_next = cur_reg.wide ? alu_v[15] : alu_v[7];
        end
        case (cur_reg.dst_part)
            PART_LO: reg_new = {rf_dst_q[15:8], v[7:0]};
            PART_HI: reg_new = {v[7:0], rf_dst_q[7:0]};
            default: reg_new = v;
        endcase
        seq_ip = ip_reg + {13'd0, cur_reg.len};
        fin_ip = ((cur_reg.op == OP_JNZ) && !zf_reg) ? seq_ip + cur_reg.imm : seq_ip;

        res               = '0;
        res.sequential_ip = seq_ip;
        res.final_ip      = fin_ip;
        res.zero_flag     = zf_next;
        res.sign_flag     = sf_next;
        res.unsupported   = (cur_reg.op == OP_UNSUP);
        res.result_value  = (reg_store || mem_store || cur_reg.op == OP_CMP) ? v : 16'h0000;
    end

    always_comb
    begin
        if (clearing)
        begin
            even_we    = 1'b1;
            even_waddr = clr_idx_reg;
            even_wdata = 8'h00;
            odd_we     = 1'b1;
            odd_waddr  = clr_idx_reg;
            odd_wdata  = 8'h00;
            rf_we      = (clr_idx_reg < BANK_W'(NUM_REGS));
            rf_waddr   = clr_idx_reg[RF_W-1:0];
            rf_wdata   = 16'h0000;
        end
        else
        begin
            even_we    = commit && mem_store && (!odd_addr || cur_reg.wide);
            even_waddr = odd_addr ? ex_base + 1'b1 : ex_base;
            even_wdata = odd_addr ? v[15:8] : v[7:0];
            odd_we     = commit && mem_store && (odd_addr || cur_reg.wide);
            odd_waddr  = ex_base;
            odd_wdata  = odd_addr ? v[7:0] : v[15:8];
            rf_we      = commit && reg_store;
            rf_waddr   = cur_reg.dst_reg;
            rf_wdata   = reg_new;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == BANK_W'(BANK_DEPTH - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_READ;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            ip_reg        <= '0;
            zf_reg        <= 1'b0;
            sf_reg        <= 1'b0;
            bx_reg        <= '0;
            bp_reg        <= '0;
            si_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (commit)
            begin
                ip_reg        <= fin_ip;
                zf_reg        <= zf_next;
                sf_reg        <= sf_next;
                out_valid_reg <= 1'b1;
                if (reg_store && cur_reg.dst_reg == REG_BX)
                begin
                    bx_reg <= reg_new;
                end
                if (reg_store && cur_reg.dst_reg == REG_BP)
                begin
                    bp_reg <= reg_new;
                end
                if (reg_store && cur_reg.dst_reg == REG_SI)
                begin
                    si_reg <= reg_new;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg  <= uop;
            addr_reg <= addr_calc;
        end
        if (commit)
        begin
            out_data_reg <= res;
        end
    end

    x86e_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_even (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (start),
        .raddr (even_raddr),
        .rdata (even_q)
    );

    x86e_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_odd (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (start),
        .raddr (odd_raddr),
        .rdata (odd_q)
    );

    x86e_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_rf_dst (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (start),
        .raddr (uop.dst_reg),
        .rdata (rf_dst_q)
    );

    x86e_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_rf_src (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (start),
        .raddr (uop.src_reg),
        .rdata (rf_src_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hw/rtl/x86_16bit_execute_subset_top.sv
// Channel | Direction | tdata fields, lowest bit first
// s_*     | in        | opcode 3, wide 1, dst_kind 2, dst_reg 3, dst_part 2, src_kind 2,
//         |           | src_reg 3, src_part 2, addr_mode 2, displacement 16,
//         |           | immediate 16, length 3, zero pad 1 (56 bits)
// m_*     | out       | sequential_ip 16, final_ip 16, zero_flag 1, sign_flag 1,
//         |           | unsupported 1, result_value 16, zero pad 5 (56 bits)
//
// The execute stage reads the register file and the memory banks in ST_READ, then
// computes and writes back in ST_EXEC once the output register is free or m_tready is
// high. After reset the memory is cleared, one word per cycle over the MEM_BYTES/2 bank
// addresses, and s_tready stays low during that pass. A two-item queue and the output
// register let input acceptance continue while a result waits on m_tready.
module x86_16bit_execute_subset_top import x86e_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // opcode .. length, see table above
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // sequential_ip .. result_value, see table above
);

    logic uop_valid;
    uop_t uop;
    logic uop_pop;
    logic clearing;

    x86e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .clearing  (clearing),
        .uop_valid (uop_valid),
        .uop       (uop),
        .uop_pop   (uop_pop)
    );

    x86e_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_valid (uop_valid),
        .uop       (uop),
        .uop_pop   (uop_pop),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hw/rtl/x86e_checker.sv
module x86e_checker import x86e_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int MAX_OUT = QUEUE_DEPTH + 2;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result without a pending item");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == CNT_W'(MAX_OUT) |-> !s_tready)
        else $error("item accepted beyond internal capacity");

    a_unsup: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34] |-> m_tdata[31:16] == m_tdata[15:0] && m_tdata[50:35] == 16'h0)
        else $error("unsupported item changed IP flow or produced a value");

endmodule

bind x86_16bit_execute_subset_top x86e_checker u_checker (.*);
